// File: rtl/core/usp_pkg.sv
package usp_pkg;

	// Fixed field widths
	localparam int MAX_GRID   = 4096;
	localparam int GRID_W     = 13;
	localparam int COORD_W    = 12;
	localparam int NUM_W      = 25;
	localparam int COLOR_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Remainder unit: dividend padded to an even bit count, two bits a step
	localparam int DVD_W     = 26;
	localparam int DIV_W     = 13;
	localparam int REM_STEPS = DVD_W / 2;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE  = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
	} usp_in_t;

	typedef struct packed {
		logic [NUM_W-1:0]   spiral_number;
		logic               is_prime;
		logic [COLOR_W-1:0] pixel_red;
		logic [COLOR_W-1:0] pixel_green;
		logic [COLOR_W-1:0] pixel_blue;
	} usp_out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic map_en;
		logic init_p;
		logic div_start;
		logic adv_p;
		logic set_verdict;
		logic verdict;
		logic emit;
	} usp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic n_lt2;
		logic sq_gt_n;
		logic rem_valid;
		logic rem_zero;
		logic out_free;
	} usp_sts_t;

endpackage

// File: rtl/core/ulam_spiral_prime_pixel_unit.sv
// Ulam spiral prime pixel unit.
// Input channel (in_valid/in_ready/in_data) takes one cell (row, column) of a
// square grid; output channel (out_valid/out_ready/out_data) returns its
// spiral number, a prime flag and a pixel colour (black for a prime, the
// fill colour otherwise). cfg_we/cfg_index/cfg_data write grid_size and the
// three fill components; write them only while the unit is idle.
// One item is worked at a time. After the accept edge the cell is mapped to its
// spiral number and the test is set up; a number below two goes straight to the
// finish. Otherwise divisors are tried from 2 up to floor(sqrt(n)), each with a
// check step and a pass through the two-bit remainder unit, until one leaves no
// remainder (a composite) or the next square exceeds n (a prime). The
// input reopens the cycle after the result is loaded. The remainder unit
// sets the rate.
// The result sits in an output register; when the receiver stalls the unit
// finishes the next item and holds it until the register frees.
// Reset clears the controller and the output valid flag and loads the
// registers with grid_size 1024 and fill colour (0, 0, 255).
module ulam_spiral_prime_pixel_unit
	import usp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  usp_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output usp_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	usp_cmd_t cmd;
	usp_sts_t sts;

	usp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	usp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An accepted item keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened right after accept");

	// A prime result is black
	a_prime_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_prime |->
			out_data.pixel_red == '0 && out_data.pixel_green == '0 &&
			out_data.pixel_blue == '0)
		else $error("prime pixel not black");

	// A prime is at least two
	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_prime |-> out_data.spiral_number >= NUM_W'(2))
		else $error("prime flag on number below two");

	// No result appears right after an item enters
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared with no work done");

endmodule

// File: rtl/core/usp_rem.sv
module usp_rem
	import usp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             valid,
	output logic             zero
);

	logic [DVD_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W-1:0]     rem_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 valid_q;
	logic [DIV_W:0]       t1;
	logic [DIV_W:0]       t2;
	logic [DIV_W-1:0]     r1;
	logic [DIV_W-1:0]     r2;

	// Two restoring subtract steps per cycle
	always_comb begin
		t1 = {rem_q, dvd_q[DVD_W-1]};
		if (t1 >= {1'b0, dvs_q}) begin
			t1 = t1 - {1'b0, dvs_q};
		end
		r1 = t1[DIV_W-1:0];
		t2 = {r1, dvd_q[DVD_W-2]};
		if (t2 >= {1'b0, dvs_q}) begin
			t2 = t2 - {1'b0, dvs_q};
		end
		r2 = t2[DIV_W-1:0];
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == REM_CNT_W'(REM_STEPS - 1)) begin
				busy_q  <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	// Hold the operands and the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {{(DVD_W - NUM_W){1'b0}}, dividend};
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-3:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign valid = valid_q;
	assign zero  = (rem_q == '0);

endmodule

// File: rtl/core/usp_datapath.sv
module usp_datapath
	import usp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  usp_cmd_t              cmd,
	output usp_sts_t              sts,
	input  usp_in_t               in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output usp_out_t              out_data
);

	// Configuration registers
	logic [GRID_W-1:0]  grid_size_q;
	logic [COLOR_W-1:0] fill_red_q;
	logic [COLOR_W-1:0] fill_green_q;
	logic [COLOR_W-1:0] fill_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q  <= GRID_W'(1024);
			fill_red_q   <= '0;
			fill_green_q <= '0;
			fill_blue_q  <= COLOR_W'(255);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_SIZE:  grid_size_q  <= cfg_data[GRID_W-1:0];
				CFG_FILL_RED:   fill_red_q   <= cfg_data[COLOR_W-1:0];
				CFG_FILL_GREEN: fill_green_q <= cfg_data[COLOR_W-1:0];
				CFG_FILL_BLUE:  fill_blue_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp size and coordinates on load
	logic [GRID_W-1:0]  size_eff;
	logic [COORD_W-1:0] lim;
	logic [COORD_W-1:0] r_cl_q;
	logic [COORD_W-1:0] c_cl_q;
	logic [COORD_W-2:0] hr_q;
	logic [COORD_W-1:0] hc_q;

	always_comb begin
		if (grid_size_q == '0) begin
			size_eff = GRID_W'(1);
		end else if (grid_size_q > GRID_W'(MAX_GRID)) begin
			size_eff = GRID_W'(MAX_GRID);
		end else begin
			size_eff = grid_size_q;
		end
		lim = COORD_W'(size_eff - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_cl_q <= (in_data.row > lim) ? lim : in_data.row;
			c_cl_q <= (in_data.column > lim) ? lim : in_data.column;
			hr_q   <= lim[COORD_W-1:1];
			hc_q   <= size_eff[GRID_W-1:1];
		end
	end

	// Map to spiral number over four stages
	logic signed [13:0] dr_s1;
	logic signed [13:0] dc_s1;
	logic [12:0]        ar;
	logic [12:0]        ac;
	logic [12:0]        mx;
	logic [12:0]        l_s2;
	logic signed [13:0] sum_s2;
	logic               ge_s2;
	logic signed [13:0] lm1;
	logic signed [27:0] sq_full;
	logic signed [15:0] l3;
	logic signed [15:0] sum16;
	logic signed [15:0] off;
	logic [NUM_W-1:0]   sq_s3;
	logic signed [15:0] off_s3;
	logic signed [26:0] n_full;
	logic [NUM_W-1:0]   n_s4;

	always_comb begin
		ar      = dr_s1[13] ? 13'(-dr_s1) : dr_s1[12:0];
		ac      = dc_s1[13] ? 13'(-dc_s1) : dc_s1[12:0];
		mx      = (ar > ac) ? ar : ac;
		lm1     = $signed({1'b0, l_s2}) - 14'sd1;
		sq_full = lm1 * lm1;
		l3      = $signed({3'b000, l_s2});
		sum16   = $signed({{2{sum_s2[13]}}, sum_s2});
		off     = ge_s2 ? ((l3 <<< 1) + l3 + sum16) : (l3 - sum16);
		n_full  = $signed({2'b00, sq_s3}) + $signed({{11{off_s3[15]}}, off_s3});
	end

	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			dr_s1  <= $signed({2'b00, r_cl_q}) - $signed({3'b000, hr_q});
			dc_s1  <= $signed({2'b00, c_cl_q}) - $signed({2'b00, hc_q});
			l_s2   <= 13'({mx, 1'b0});
			sum_s2 <= dr_s1 + dc_s1;
			ge_s2  <= (dc_s1 >= dr_s1);
			sq_s3  <= sq_full[NUM_W-1:0];
			off_s3 <= off;
			n_s4   <= n_full[NUM_W-1:0];
		end
	end

	// Trial divisor and its square
	logic [DIV_W-1:0] p_q;
	logic [DVD_W-1:0] psq_q;

	always_ff @(posedge clk) begin
		if (cmd.init_p) begin
			p_q   <= DIV_W'(2);
			psq_q <= DVD_W'(4);
		end else if (cmd.adv_p) begin
			p_q   <= p_q + 1'b1;
			psq_q <= psq_q + {{(DVD_W - DIV_W - 1){1'b0}}, p_q, 1'b1};
		end
	end

	logic rem_valid;
	logic rem_zero;

	usp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_s4),
		.divisor  (p_q),
		.valid    (rem_valid),
		.zero     (rem_zero)
	);

	// Verdict
	logic verdict_q;

	always_ff @(posedge clk) begin
		if (cmd.set_verdict) begin
			verdict_q <= cmd.verdict;
		end
	end

	// Output register
	logic     out_valid_q;
	usp_out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.spiral_number <= n_s4;
			out_data_q.is_prime      <= verdict_q;
			out_data_q.pixel_red     <= verdict_q ? '0 : fill_red_q;
			out_data_q.pixel_green   <= verdict_q ? '0 : fill_green_q;
			out_data_q.pixel_blue    <= verdict_q ? '0 : fill_blue_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Status
	assign sts.n_lt2     = (n_s4 < NUM_W'(2));
	assign sts.sq_gt_n   = (psq_q > {{(DVD_W - NUM_W){1'b0}}, n_s4});
	assign sts.rem_valid = rem_valid;
	assign sts.rem_zero  = rem_zero;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// File: rtl/core/usp_ctrl.sv
module usp_ctrl
	import usp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  usp_sts_t sts,
	output usp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAP  = 3'd1;
	localparam logic [2:0] S_TEST = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	localparam int MAP_CYCLES = 4;
	localparam int MAP_CNT_W  = $clog2(MAP_CYCLES);

	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic [MAP_CNT_W-1:0] map_cnt_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MAP;
				end
			end
			S_MAP: begin
				cmd.map_en = 1'b1;
				if (map_cnt_q == MAP_CNT_W'(MAP_CYCLES - 1)) begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				cmd.init_p = 1'b1;
				if (sts.n_lt2) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b0;
					state_d         = S_FIN;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.sq_gt_n) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b1;
					state_d         = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.rem_valid) begin
					if (sts.rem_zero) begin
						cmd.set_verdict = 1'b1;
						cmd.verdict     = 1'b0;
						state_d         = S_FIN;
					end else begin
						cmd.adv_p = 1'b1;
						state_d   = S_CHK;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Advance state and map counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			map_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MAP) begin
				map_cnt_q <= map_cnt_q + 1'b1;
			end else begin
				map_cnt_q <= '0;
			end
		end
	end

endmodule
